// File: hdl/alpha_blend_pixel_pack_defines.svh
// Assertion macros for the pixel blend/pack block.
// ABPP_ASSERT is disabled while rst_n is low; ABPP_ASSERT_RST also checks across reset.
`ifndef ALPHA_BLEND_PIXEL_PACK_DEFINES_SVH
`define ALPHA_BLEND_PIXEL_PACK_DEFINES_SVH

`ifndef SYNTHESIS

`define ABPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ABPP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ABPP_ASSERT(lbl, prop, msg)

`define ABPP_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// File: hdl/abpp_pkg.sv
package abpp_pkg;

  localparam int FIFO_DEPTH = 2;

  // depth_mode codes
  localparam logic [1:0] DEPTH_8   = 2'd0;
  localparam logic [1:0] DEPTH_565 = 2'd1;
  localparam logic [1:0] DEPTH_888 = 2'd2;

  // register indexes
  localparam logic [1:0] REG_DEPTH_MODE   = 2'd0;
  localparam logic [1:0] REG_BGR_ORDER    = 2'd1;
  localparam logic [1:0] REG_BLEND_ENABLE = 2'd2;

  localparam logic [1:0] DEPTH_MODE_RST   = DEPTH_888;
  localparam logic       BGR_ORDER_RST    = 1'b1;
  localparam logic       BLEND_ENABLE_RST = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [1:0] depth_mode;
    logic       bgr_order;
    logic       blend_enable;
  } cfg_t;

  // one classified word between front and back
  typedef struct packed {
    logic        keep;       // no write: destination passes through
    logic [7:0]  alpha;      // effective alpha, opaque for plain copies
    logic [7:0]  src_r;
    logic [7:0]  src_g;
    logic [7:0]  src_b;
    logic [7:0]  dst_r;
    logic [7:0]  dst_g;
    logic [7:0]  dst_b;
    logic [23:0] dst_masked;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// File: hdl/abpp_front.sv
module abpp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  abpp_pkg::cfg_t  cfg,
  input  logic            in_push,
  input  logic [31:0]     in_src_argb,
  input  logic [23:0]     in_dst_pixel,
  output logic            in_ready,
  output abpp_pkg::entry_t fe_entry,
  output logic            fe_valid,
  input  logic            fe_ready
);
  import abpp_pkg::*;

  logic   vld_r, vld_nxt;
  entry_t ent_r, ent_nxt;
  logic [23:0] dmask;
  logic [7:0]  a;
  logic        take;

  assign in_ready = !vld_r || fe_ready;
  assign take     = in_push && in_ready;
  assign a        = in_src_argb[31:24];

  always_comb begin
    unique case (cfg.depth_mode)
      DEPTH_888: dmask = in_dst_pixel;
      DEPTH_565: dmask = {8'd0, in_dst_pixel[15:0]};
      default:   dmask = {16'd0, in_dst_pixel[7:0]};
    endcase
  end

  always_comb begin
    ent_nxt            = ent_r;
    ent_nxt.src_r      = in_src_argb[23:16];
    ent_nxt.src_g      = in_src_argb[15:8];
    ent_nxt.src_b      = in_src_argb[7:0];
    ent_nxt.dst_masked = dmask;
    unique case (cfg.depth_mode)
      DEPTH_888: begin
        if (cfg.bgr_order) begin
          ent_nxt.dst_r = dmask[23:16];
          ent_nxt.dst_b = dmask[7:0];
        end else begin
          ent_nxt.dst_r = dmask[7:0];
          ent_nxt.dst_b = dmask[23:16];
        end
        ent_nxt.dst_g = dmask[15:8];
      end
      DEPTH_565: begin
        ent_nxt.dst_r = {dmask[15:11], 3'd0};
        ent_nxt.dst_g = {dmask[10:5], 2'd0};
        ent_nxt.dst_b = {dmask[4:0], 3'd0};
      end
      default: begin
        ent_nxt.dst_r = 8'd0;
        ent_nxt.dst_g = 8'd0;
        ent_nxt.dst_b = dmask[7:0];
      end
    endcase
    // opaque copy runs through the blend with alpha 255, which returns the source exactly
    priority if (!cfg.blend_enable || a == ALPHA_OPAQUE) begin
      ent_nxt.keep  = 1'b0;
      ent_nxt.alpha = ALPHA_OPAQUE;
    end else if (a == 8'd0) begin
      ent_nxt.keep  = 1'b1;
      ent_nxt.alpha = 8'd0;
    end else begin
      ent_nxt.keep  = 1'b0;
      ent_nxt.alpha = a;
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (in_ready) vld_nxt = in_push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) ent_r <= ent_nxt;
  end

  assign fe_entry = ent_r;
  assign fe_valid = vld_r;

endmodule

// File: hdl/abpp_fifo.sv
module abpp_fifo #(
  parameter int DEPTH = abpp_pkg::FIFO_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  abpp_pkg::entry_t     wr_data,
  input  logic                 rd_en,
  output abpp_pkg::entry_t     rd_data,
  output abpp_pkg::fifo_stat_t stat
);
  import abpp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t        mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign stat.full  = (cnt_r == FULL_CNT);
  assign stat.empty = (cnt_r == '0);
  assign do_wr   = wr_en && !stat.full;
  assign do_rd   = rd_en && !stat.empty;
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) wp_nxt = (wp_r == LAST) ? '0 : wp_r + 1'b1;
    if (do_rd) rp_nxt = (rp_r == LAST) ? '0 : rp_r + 1'b1;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

endmodule

// File: hdl/abpp_back.sv
module abpp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  abpp_pkg::cfg_t   cfg,
  input  abpp_pkg::entry_t be_entry,
  input  logic             be_valid,
  output logic             be_take,
  input  logic             pop,
  output logic             empty,
  output logic [23:0]      out_pixel,
  output logic             out_write_enable
);
  import abpp_pkg::*;

  localparam logic [15:0] RECIP_255 = 16'h8081;  // x/255 == (x*0x8081)>>23 for 16-bit x

  logic        v1_r, v1_nxt, v2_r, v2_nxt;
  logic        s1_ready, s2_ready;
  logic        keep1_r;
  logic [23:0] dmask1_r;
  logic [15:0] xr_r, xg_r, xb_r;
  logic [15:0] xr_nxt, xg_nxt, xb_nxt;
  logic [7:0]  ia;
  logic [31:0] pr, pg, pb;
  logic [7:0]  qr, qg, qb;
  logic [23:0] pix_nxt, pix_r;
  logic        we_r;

  assign s2_ready = !v2_r || pop;
  assign s1_ready = !v1_r || s2_ready;
  assign be_take  = be_valid && s1_ready;

  // stage 1: weighted sums per channel, at most 255*255 so 16 bits hold them
  assign ia = ALPHA_OPAQUE - be_entry.alpha;
  assign xr_nxt = 16'(be_entry.src_r) * 16'(be_entry.alpha) + 16'(be_entry.dst_r) * 16'(ia);
  assign xg_nxt = 16'(be_entry.src_g) * 16'(be_entry.alpha) + 16'(be_entry.dst_g) * 16'(ia);
  assign xb_nxt = 16'(be_entry.src_b) * 16'(be_entry.alpha) + 16'(be_entry.dst_b) * 16'(ia);

  // stage 2: divide by 255, then pack
  assign pr = xr_r * RECIP_255;
  assign pg = xg_r * RECIP_255;
  assign pb = xb_r * RECIP_255;
  assign qr = pr[30:23];
  assign qg = pg[30:23];
  assign qb = pb[30:23];

  always_comb begin
    if (keep1_r) begin
      pix_nxt = dmask1_r;
    end else begin
      unique case (cfg.depth_mode)
        DEPTH_888: pix_nxt = cfg.bgr_order ? {qr, qg, qb} : {qb, qg, qr};
        DEPTH_565: pix_nxt = {8'd0, qr[7:3], qg[7:2], qb[7:3]};
        default:   pix_nxt = {16'd0, qb};
      endcase
    end
  end

  always_comb begin
    v1_nxt = v1_r;
    v2_nxt = v2_r;
    if (s1_ready) v1_nxt = be_valid;
    if (s2_ready) v2_nxt = v1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (be_take) begin
      xr_r     <= xr_nxt;
      xg_r     <= xg_nxt;
      xb_r     <= xb_nxt;
      keep1_r  <= be_entry.keep;
      dmask1_r <= be_entry.dst_masked;
    end
    if (s2_ready && v1_r) begin
      pix_r <= pix_nxt;
      we_r  <= !keep1_r;
    end
  end

  assign empty            = !v2_r;
  assign out_pixel        = pix_r;
  assign out_write_enable = we_r;

endmodule

// File: hdl/alpha_blend_pixel_pack.sv
// Source-over alpha blend and native pixel pack. One word per cycle sustained in both
// directions while the consumer keeps popping; an accepted word passes the front register,
// the classify queue and two back stages (weighted sums, then the reciprocal divide by 255
// and pack) before it reaches the result ports. Results come out in push order with a write
// enable that is low only for fully transparent source pixels while blending is on.
// Registers at byte addresses 0 (depth_mode), 4 (bgr_order) and 8 (blend_enable) may be
// written only while the block is idle.
`include "alpha_blend_pixel_pack_defines.svh"

module alpha_blend_pixel_pack #(
  parameter int FIFO_DEPTH = abpp_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_src_argb,
  input  logic [23:0] in_dst_pixel,
  output logic        empty,
  input  logic        pop,
  output logic [23:0] out_pixel,
  output logic        out_write_enable,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import abpp_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  entry_t     fe_entry, be_entry;
  logic       fe_valid, fe_ready, in_ready;
  logic       be_take;
  fifo_stat_t fifo_stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_DEPTH_MODE:   cfg_nxt.depth_mode   = pwdata[1:0];
        REG_BGR_ORDER:    cfg_nxt.bgr_order    = pwdata[0];
        REG_BLEND_ENABLE: cfg_nxt.blend_enable = pwdata[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEPTH_MODE:   prdata = {30'd0, cfg_r.depth_mode};
      REG_BGR_ORDER:    prdata = {31'd0, cfg_r.bgr_order};
      REG_BLEND_ENABLE: prdata = {31'd0, cfg_r.blend_enable};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_mode   <= DEPTH_MODE_RST;
      cfg_r.bgr_order    <= BGR_ORDER_RST;
      cfg_r.blend_enable <= BLEND_ENABLE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign fe_ready = !fifo_stat.full;
  assign full     = !in_ready;

  abpp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_push      (push),
    .in_src_argb  (in_src_argb),
    .in_dst_pixel (in_dst_pixel),
    .in_ready     (in_ready),
    .fe_entry     (fe_entry),
    .fe_valid     (fe_valid),
    .fe_ready     (fe_ready)
  );

  abpp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fe_valid),
    .wr_data (fe_entry),
    .rd_en   (be_take),
    .rd_data (be_entry),
    .stat    (fifo_stat)
  );

  abpp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .be_entry         (be_entry),
    .be_valid         (!fifo_stat.empty),
    .be_take          (be_take),
    .pop              (pop),
    .empty            (empty),
    .out_pixel        (out_pixel),
    .out_write_enable (out_write_enable)
  );

  `ABPP_ASSERT_RST(a_reset_empty, !rst_n |=> empty, "result queue not empty after reset")
  `ABPP_ASSERT(a_full_backpressure, full |-> fifo_stat.full, "full without queue backpressure")
  `ABPP_ASSERT(a_fifo_flags, !(fifo_stat.full && fifo_stat.empty), "queue full and empty")

endmodule

// File: bench/alpha_blend_pixel_pack_test.sv
`timescale 1ns / 1ps

module alpha_blend_pixel_pack_test;
  import abpp_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int WORDS_PER_PHASE = 40;

  class blend_scoreboard;
    typedef struct {
      logic [23:0] pixel;
      logic        we;
    } pixel_write_t;

    pixel_write_t expected_writes[$];
    int errors;
    int checked;
    int held;

    function logic [23:0] width_mask(cfg_t c);
      case (c.depth_mode)
        DEPTH_565: return 24'h00FFFF;
        DEPTH_888: return 24'hFFFFFF;
        default:   return 24'h0000FF;
      endcase
    endfunction

    function logic [23:0] pack_native(cfg_t c, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      case (c.depth_mode)
        DEPTH_888: return c.bgr_order ? {r, g, b} : {b, g, r};
        DEPTH_565: return {8'h00, r[7:3], g[7:2], b[7:3]};
        default:   return {16'h0000, b};
      endcase
    endfunction

    function void unpack_native(cfg_t c, logic [23:0] v,
                                output logic [7:0] r, output logic [7:0] g,
                                output logic [7:0] b);
      case (c.depth_mode)
        DEPTH_888: begin
          g = v[15:8];
          r = c.bgr_order ? v[23:16] : v[7:0];
          b = c.bgr_order ? v[7:0] : v[23:16];
        end
        DEPTH_565: begin
          r = {v[15:11], 3'b000};
          g = {v[10:5], 2'b00};
          b = {v[4:0], 3'b000};
        end
        default: begin
          r = 8'h00;
          g = 8'h00;
          b = v[7:0];
        end
      endcase
    endfunction

    function logic [7:0] mix_channel(logic [7:0] s, logic [7:0] d, logic [7:0] a);
      int unsigned sum;
      sum = int'(s) * int'(a) + int'(d) * (255 - int'(a));
      return 8'(sum / 255);
    endfunction

    function void blend_pixel(cfg_t c, logic [31:0] src, logic [23:0] dst,
                              output logic [23:0] pix, output logic we);
      logic [23:0] mask;
      logic [23:0] dst_m;
      logic [7:0]  a;
      logic [7:0]  dr, dg, db;
      mask  = width_mask(c);
      dst_m = dst & mask;
      a     = src[31:24];
      we    = 1'b1;
      if (!c.blend_enable || a == ALPHA_OPAQUE) begin
        pix = pack_native(c, src[23:16], src[15:8], src[7:0]);
      end else if (a == 8'h00) begin
        // transparent: destination passes through untouched
        pix = dst_m;
        we  = 1'b0;
      end else begin
        unpack_native(c, dst_m, dr, dg, db);
        pix = pack_native(c, mix_channel(src[23:16], dr, a),
                          mix_channel(src[15:8], dg, a),
                          mix_channel(src[7:0], db, a));
      end
      pix = pix & mask;
    endfunction

    function void note_word(cfg_t c, logic [31:0] src, logic [23:0] dst);
      pixel_write_t w;
      blend_pixel(c, src, dst, w.pixel, w.we);
      if (!w.we) held++;
      expected_writes.push_back(w);
    endfunction

    function void check_word(logic [23:0] pix, logic we);
      pixel_write_t w;
      checked++;
      if (expected_writes.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, got pixel %06h we %0b", $time, pix, we);
        return;
      end
      w = expected_writes.pop_front();
      if (pix !== w.pixel) begin
        errors++;
        $display("%0t: out_pixel expected %06h got %06h", $time, w.pixel, pix);
      end
      if (we !== w.we) begin
        errors++;
        $display("%0t: out_write_enable expected %0b got %0b", $time, w.we, we);
      end
    endfunction

    function int depth();
      return expected_writes.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [31:0] in_src_argb;
  logic [23:0] in_dst_pixel;
  logic        empty;
  logic        pop;
  logic [23:0] out_pixel;
  logic        out_write_enable;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  blend_scoreboard sb = new();
  cfg_t active_cfg;
  bit   calm;
  int   pop_hold;
  int   cycle_count;
  int   reg_errors;
  int   phases;

  alpha_blend_pixel_pack uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_src_argb      (in_src_argb),
    .in_dst_pixel     (in_dst_pixel),
    .empty            (empty),
    .pop              (pop),
    .out_pixel        (out_pixel),
    .out_write_enable (out_write_enable),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // both handshakes are judged on pre-edge values
  always @(posedge clk) begin
    if (rst_n && push && !full) sb.note_word(active_cfg, in_src_argb, in_dst_pixel);
    if (rst_n && pop && !empty) sb.check_word(out_pixel, out_write_enable);
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (calm) begin
      pop <= 1'b1;
    end else if (pop_hold > 0) begin
      pop_hold--;
      pop <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      pop_hold = $urandom_range(1, 11) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // starts and ends at a falling edge; push stays high into the next word
  task automatic send_word(input logic [31:0] src, input logic [23:0] dst);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 11);
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_src_argb  <= src;
    in_dst_pixel <= dst;
    push         <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_words();
    while (sb.depth() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // write, then read back
  task automatic program_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== val) begin
      reg_errors++;
      $display("%0t: register %0d readback expected %08h got %08h", $time, idx, val, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [1:0] d, input logic bgr, input logic blend);
    program_reg(REG_DEPTH_MODE, {30'd0, d});
    program_reg(REG_BGR_ORDER, {31'd0, bgr});
    program_reg(REG_BLEND_ENABLE, {31'd0, blend});
    active_cfg.depth_mode   = d;
    active_cfg.bgr_order    = bgr;
    active_cfg.blend_enable = blend;
    phases++;
  endtask

  function automatic logic [31:0] random_src();
    logic [7:0]  a;
    logic [23:0] rgb;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2)       a = 8'h00;
    else if (pick < 4)  a = ALPHA_OPAQUE;
    else if (pick == 4) a = $urandom_range(0, 1) ? 8'h01 : 8'hFE;
    else                a = 8'($urandom);
    pick = $urandom_range(0, 9);
    if (pick == 0)      rgb = 24'h000000;
    else if (pick == 1) rgb = 24'hFFFFFF;
    else                rgb = 24'($urandom);
    return {a, rgb};
  endfunction

  function automatic logic [23:0] random_dst();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 24'h000000;
    if (pick == 1) return 24'hFFFFFF;
    return 24'($urandom);
  endfunction

  initial begin
    rst_n        = 1'b0;
    push         = 1'b0;
    in_src_argb  = '0;
    in_dst_pixel = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    calm         = 1'b0;
    pop_hold     = 0;
    cycle_count  = 0;
    reg_errors   = 0;
    phases       = 1;
    active_cfg.depth_mode   = DEPTH_MODE_RST;
    active_cfg.bgr_order    = BGR_ORDER_RST;
    active_cfg.blend_enable = BLEND_ENABLE_RST;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: transparent, opaque, near-edge alphas, field extremes
    send_word(32'h00FFFFFF, 24'h123456);
    send_word(32'h00000000, 24'hFFFFFF);
    send_word(32'hFF123456, 24'hABCDEF);
    send_word(32'hFFFFFFFF, 24'h000000);
    send_word(32'h01FFFFFF, 24'h000000);
    send_word(32'h01000000, 24'hFFFFFF);
    send_word(32'hFE000000, 24'hFFFFFF);
    send_word(32'hFEFFFFFF, 24'h000000);
    send_word(32'h80FF0000, 24'h00FF00);
    send_word(32'h7F808080, 24'h7F7F7F);
    send_word(32'hAA55AA55, 24'hAA55AA);
    send_word(32'h55AA55AA, 24'h55AA55);
    push <= 1'b0;
    drain_words();

    // every setting, unused depth code last
    for (int p = 0; p < 16; p++) begin
      set_config(2'(p >> 2), p[1], p[0]);
      if (p >= 14) calm = 1'b1;
      for (int k = 0; k < WORDS_PER_PHASE; k++) send_word(random_src(), random_dst());
      push <= 1'b0;
      drain_words();
    end

    repeat (8) @(posedge clk);
    $display("Checked %0d words over %0d register settings, %0d of them held back",
             sb.checked, phases, sb.held);
    if (sb.errors == 0 && reg_errors == 0 && sb.depth() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: alpha_blend_pixel_pack.f
+incdir+hdl
hdl/abpp_pkg.sv
hdl/abpp_front.sv
hdl/abpp_fifo.sv
hdl/abpp_back.sv
hdl/alpha_blend_pixel_pack.sv
bench/alpha_blend_pixel_pack_test.sv
